// ===== rtl/core/pkh_pkg.sv =====
// Shared types and codes for the point-key hash table.
// Used by every module of the block but pkh_ram; depends on nothing.
`default_nettype none

package pkh_pkg;

   localparam int OP_W          = 2;
   localparam int ST_W          = 2;
   localparam int FIELD_W       = 8;
   // bits of the pairing value folded into the bucket remainder per cycle
   localparam int MOD_STEP_BITS = 8;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic [ST_W-1:0]    status;
      logic [FIELD_W-1:0] result_x;
      logic [FIELD_W-1:0] result_y;
   } rsp_type;

   typedef struct packed {
      logic    write;
      rsp_type rsp;
   } upd_type;

endpackage

`default_nettype wire

// ===== rtl/core/pkh_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module pkh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pkh_bucket_hash.sv =====
// Bucket index unit: Cantor pairing of the key, reduced modulo the bucket count.
// Depends on pkh_pkg for the remainder step size.
`default_nettype none

module pkh_bucket_hash import pkh_pkg::*; #(
   parameter int BUCKETS    = 64,
   parameter int COORD_BITS = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [COORD_BITS-1:0]      key_x,
   input  wire logic [COORD_BITS-1:0]      key_y,
   output logic                            done,
   output logic      [$clog2(BUCKETS)-1:0] bucket
);

   localparam int   BW      = $clog2(BUCKETS);
   localparam int   SW      = COORD_BITS + 1;
   localparam int   PRW     = 2 * SW;
   localparam logic IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

   localparam logic [1:0] H_IDLE = 2'd0;
   localparam logic [1:0] H_ADD  = 2'd1;
   localparam logic [1:0] H_MOD  = 2'd2;

   logic [1:0]            phase_ff;
   logic [SW-1:0]         sum;
   logic [SW-1:0]         sum_p1;
   logic [PRW-1:0]        prod_ff;
   logic [COORD_BITS-1:0] y_ff;
   logic [PRW-1:0]        pair;

   assign sum    = SW'(key_x) + SW'(key_y);
   assign sum_p1 = sum + SW'(1);

   // s*(s+1) is always even, so the halving is exact
   assign pair = (prod_ff >> 1) + PRW'(y_ff);

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= PRW'(sum) * PRW'(sum_p1);
         y_ff    <= key_y;
      end
   end

   generate
      if (IS_POW2) begin : g_mask
         assign done   = (phase_ff == H_ADD);
         assign bucket = pair[BW-1:0];

         always_ff @(posedge clock) begin
            if (reset) begin
               phase_ff <= H_IDLE;
            end else begin
               unique case (phase_ff)
                  H_IDLE:  if (start) phase_ff <= H_ADD;
                  default: phase_ff <= H_IDLE;
               endcase
            end
         end
      end else begin : g_mod
         localparam int NSTEPS = (PRW + MOD_STEP_BITS - 1) / MOD_STEP_BITS;
         localparam int PADW   = NSTEPS * MOD_STEP_BITS;
         localparam int CW     = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;

         logic [PADW-1:0] p_ff;
         logic [BW-1:0]   r_ff;
         logic [CW-1:0]   cnt_ff;
         logic [BW:0]     r_acc;
         logic [BW-1:0]   r_next;

         // shift in one bit at a time, subtract the modulus when it overflows
         always_comb begin
            r_acc = {1'b0, r_ff};
            for (int i = 0; i < MOD_STEP_BITS; i++) begin
               r_acc = {r_acc[BW-1:0], p_ff[PADW-1-i]};
               if (r_acc >= (BW+1)'(BUCKETS)) begin
                  r_acc = r_acc - (BW+1)'(BUCKETS);
               end
            end
            r_next = r_acc[BW-1:0];
         end

         assign done   = (phase_ff == H_MOD) && (cnt_ff == CW'(NSTEPS - 1));
         assign bucket = r_next;

         always_ff @(posedge clock) begin
            if (reset) begin
               phase_ff <= H_IDLE;
            end else begin
               unique case (phase_ff)
                  H_IDLE: if (start) phase_ff <= H_ADD;
                  H_ADD:  phase_ff <= H_MOD;
                  H_MOD:  if (done) phase_ff <= H_IDLE;
                  default: phase_ff <= H_IDLE;
               endcase
            end
         end

         always_ff @(posedge clock) begin
            if (phase_ff == H_ADD) begin
               p_ff   <= PADW'(pair);
               r_ff   <= '0;
               cnt_ff <= '0;
            end else if (phase_ff == H_MOD) begin
               p_ff   <= p_ff << MOD_STEP_BITS;
               r_ff   <= r_next;
               cnt_ff <= cnt_ff + CW'(1);
            end
         end
      end
   endgenerate

endmodule

`default_nettype wire

// ===== rtl/core/pkh_row_update.sv =====
// Bucket row modify logic: match across ways, insert in front, find, delete.
// Depends on pkh_pkg for opcodes, status codes and the update struct.
`default_nettype none

module pkh_row_update import pkh_pkg::*; #(
   parameter int WAYS       = 4,
   parameter int COORD_BITS = 8
) (
   input  wire logic [OP_W-1:0]                                   opcode,
   input  wire logic [COORD_BITS-1:0]                             key_x,
   input  wire logic [COORD_BITS-1:0]                             key_y,
   input  wire logic [COORD_BITS-1:0]                             value_x,
   input  wire logic [COORD_BITS-1:0]                             value_y,
   input  wire logic [WAYS*4*COORD_BITS+$clog2(WAYS+1)-1:0]       row_in,
   output logic      [WAYS*4*COORD_BITS+$clog2(WAYS+1)-1:0]       row_out,
   output upd_type                                                upd
);

   localparam int FW    = $clog2(WAYS + 1);
   localparam int ENT_W = 4 * COORD_BITS;
   localparam int ROW_W = WAYS * ENT_W + FW;
   localparam int WB    = (WAYS > 1) ? $clog2(WAYS) : 1;

   logic [FW-1:0]    fill;
   logic [FW-1:0]    new_fill;
   logic [ENT_W-1:0] ent     [WAYS];
   logic [ENT_W-1:0] new_ent [WAYS];
   logic             hit;
   logic [WB-1:0]    hit_way;

   always_comb begin
      fill = row_in[ROW_W-1 -: FW];
      for (int w = 0; w < WAYS; w++) begin
         ent[w] = row_in[w*ENT_W +: ENT_W];
      end

      // newest match wins: scan from the back so way 0 has priority
      hit     = 1'b0;
      hit_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if ((FW'(w) < fill) &&
             (ent[w][COORD_BITS-1:0] == key_x) &&
             (ent[w][2*COORD_BITS-1:COORD_BITS] == key_y)) begin
            hit     = 1'b1;
            hit_way = WB'(w);
         end
      end
   end

   always_comb begin
      new_fill = fill;
      for (int w = 0; w < WAYS; w++) begin
         new_ent[w] = ent[w];
      end
      upd.write        = 1'b0;
      upd.rsp.status   = ST_OK;
      upd.rsp.result_x = '0;
      upd.rsp.result_y = '0;

      unique case (opcode)
         OP_INSERT: begin
            if (fill >= FW'(WAYS)) begin
               upd.rsp.status = ST_FULL;
            end else begin
               new_ent[0] = {value_y, value_x, key_y, key_x};
               for (int w = 1; w < WAYS; w++) begin
                  new_ent[w] = ent[w-1];
               end
               new_fill  = fill + FW'(1);
               upd.write = 1'b1;
            end
         end
         OP_FIND: begin
            if (!hit) begin
               upd.rsp.status = ST_NOT_FOUND;
            end else begin
               upd.rsp.result_x = FIELD_W'(ent[hit_way][2*COORD_BITS +: COORD_BITS]);
               upd.rsp.result_y = FIELD_W'(ent[hit_way][3*COORD_BITS +: COORD_BITS]);
            end
         end
         OP_DELETE: begin
            if (!hit) begin
               upd.rsp.status = ST_NOT_FOUND;
            end else begin
               // close the gap: older entries move up one way
               for (int w = 0; w < WAYS - 1; w++) begin
                  if (w >= int'(hit_way)) begin
                     new_ent[w] = ent[w+1];
                  end
               end
               new_ent[WAYS-1] = '0;
               new_fill  = fill - FW'(1);
               upd.write = 1'b1;
            end
         end
         default: begin
            upd.rsp.status = ST_OK;
         end
      endcase

      for (int w = 0; w < WAYS; w++) begin
         row_out[w*ENT_W +: ENT_W] = new_ent[w];
      end
      row_out[ROW_W-1 -: FW] = new_fill;
   end

endmodule

`default_nettype wire

// ===== rtl/core/point_key_hash_table.sv =====
// Top level of the point-key hash table: request capture, bucket RAM, sequencer.
// Depends on pkh_pkg, pkh_ram, pkh_bucket_hash and pkh_row_update.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------------
//   req     | in        | req_tvalid/req_tready | tuser: opcode; tdata: key, value
//   rsp     | out       | rsp_tvalid/rsp_tready | tuser: status; tdata: result point
//
// A request passes through the hash step, which forms the pairing value and reads
// the bucket row, and the write-back step, which modifies the row and writes it
// back while the next request is taken; the remainder unit lengthens the hash step
// for other bucket counts. The next read follows the write, so no forwarding.
// After reset a clearing pass writes all BUCKETS rows, one per cycle, before
// the first request is taken. A stalled response holds the sequencer in its
// write-back step; one finished response waits in the output register.
`default_nettype none

module point_key_hash_table import pkh_pkg::*; #(
   parameter int BUCKETS    = 64,
   parameter int WAYS       = 4,
   parameter int COORD_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // key_x, key_y, value_x, value_y
   input  wire logic [1:0]  req_tuser,   // opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // result_x, result_y
   output logic      [1:0]  rsp_tuser    // status
);

   localparam int BW    = $clog2(BUCKETS);
   localparam int FW    = $clog2(WAYS + 1);
   localparam int ROW_W = WAYS * 4 * COORD_BITS + FW;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_HASH  = 2'd2;
   localparam logic [1:0] S_EXEC  = 2'd3;

   logic [1:0]            state_ff;
   logic [1:0]            state_in;
   logic [BW-1:0]         clear_cnt_ff;
   logic [OP_W-1:0]       op_ff;
   logic [COORD_BITS-1:0] kx_ff, ky_ff, vx_ff, vy_ff;
   logic [BW-1:0]         bucket_ff;
   logic                  rsp_tvalid_ff;
   rsp_type               rsp_ff;

   logic                  req_accept;
   logic                  out_free;
   logic                  hash_done;
   logic [BW-1:0]         hash_bucket;
   logic                  ram_wr_en;
   logic [BW-1:0]         ram_wr_addr;
   logic [ROW_W-1:0]      ram_wr_data;
   logic [ROW_W-1:0]      row_rd;
   logic [ROW_W-1:0]      row_new;
   upd_type               upd;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) || ((state_ff == S_EXEC) && out_free);
   assign req_accept = req_tvalid && req_tready;

   pkh_bucket_hash #(
      .BUCKETS    (BUCKETS),
      .COORD_BITS (COORD_BITS)
   ) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (req_accept),
      .key_x  (COORD_BITS'(req_tdata[7:0])),
      .key_y  (COORD_BITS'(req_tdata[15:8])),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   pkh_ram #(
      .WIDTH (ROW_W),
      .DEPTH (BUCKETS)
   ) u_rows (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (hash_done),
      .rd_addr (hash_bucket),
      .rd_data (row_rd)
   );

   pkh_row_update #(
      .WAYS       (WAYS),
      .COORD_BITS (COORD_BITS)
   ) u_update (
      .opcode  (op_ff),
      .key_x   (kx_ff),
      .key_y   (ky_ff),
      .value_x (vx_ff),
      .value_y (vy_ff),
      .row_in  (row_rd),
      .row_out (row_new),
      .upd     (upd)
   );

   always_comb begin
      if (state_ff == S_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_cnt_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = (state_ff == S_EXEC) && out_free && upd.write;
         ram_wr_addr = bucket_ff;
         ram_wr_data = row_new;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clear_cnt_ff == BW'(BUCKETS - 1)) state_in = S_IDLE;
         S_IDLE:  if (req_accept) state_in = S_HASH;
         S_HASH:  if (hash_done) state_in = S_EXEC;
         S_EXEC: begin
            if (out_free) begin
               state_in = req_accept ? S_HASH : S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clear_cnt_ff  <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) begin
            clear_cnt_ff <= clear_cnt_ff + BW'(1);
         end
         if ((state_ff == S_EXEC) && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // payload: capture the request, the bucket and the response
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff <= req_tuser;
         kx_ff <= COORD_BITS'(req_tdata[7:0]);
         ky_ff <= COORD_BITS'(req_tdata[15:8]);
         vx_ff <= COORD_BITS'(req_tdata[23:16]);
         vy_ff <= COORD_BITS'(req_tdata[31:24]);
      end
      if (hash_done) begin
         bucket_ff <= hash_bucket;
      end
      if ((state_ff == S_EXEC) && out_free) begin
         rsp_ff <= upd.rsp;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_ff.result_y, rsp_ff.result_x};
   assign rsp_tuser  = rsp_ff.status;

`ifndef ASSERT_OFF
   a_done_in_hash : assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (state_ff == S_HASH))
      else $error("bucket index ready outside the hash step");

   a_no_req_in_clear : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_tready)
      else $error("request taken during the clearing pass");

   a_accept_to_hash : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_HASH))
      else $error("accepted request did not enter the hash step");

   a_write_in_exec : assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && (state_ff != S_CLEAR)) |-> ((state_ff == S_EXEC) && out_free))
      else $error("row written back outside the write-back step");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench for point_key_hash_table: directed table, then random insert/find/delete traffic, plus the unused opcode.
// Predicts untyped responses from its own bucket model; depends on pkh_pkg and the RTL top.
`timescale 1ns / 100ps

module tb_top;
   import pkh_pkg::*;

   localparam int BUCKETS     = 64;
   localparam int WAYS        = 4;
   localparam int COORD_BITS  = 8;
   localparam int DIRECTED_N  = 25;
   localparam int RANDOM_N    = 825;
   localparam int PHASES      = 5;
   localparam int PRESSURE_PH = 4;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 20;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [FIELD_W-1:0] kx, ky, vx, vy;
      bit                 typed;
      rsp_type            want;
   } request_type;

   typedef struct {
      logic [FIELD_W-1:0] kx, ky, vx, vy;
   } slot_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // key_x, key_y, value_x, value_y
   logic [1:0]  req_tuser;   // opcode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // result_x, result_y
   logic [1:0]  rsp_tuser;   // status

   slot_type    bucket_rows [BUCKETS][WAYS];
   int          bucket_fill [BUCKETS];
   rsp_type     pending_rsp [$];
   request_type directed_rows [DIRECTED_N];

   int  send_idle_pct;
   int  recv_stall_pct;
   bit  hold_start;
   bit  hold_taken;
   int  hold_left;
   int  fail_count;
   int  cycle_count;

   point_key_hash_table #(
      .BUCKETS(BUCKETS), .WAYS(WAYS), .COORD_BITS(COORD_BITS)
   ) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Cantor pairing of the key, folded into the bucket count
   function automatic int bucket_index(input logic [FIELD_W-1:0] kx,
                                       input logic [FIELD_W-1:0] ky);
      int s;
      int p;
      s = int'(kx) + int'(ky);
      p = (s * (s + 1)) / 2 + int'(ky);
      return p % BUCKETS;
   endfunction

   function automatic int newest_way(input int b, input logic [FIELD_W-1:0] kx,
                                     input logic [FIELD_W-1:0] ky);
      for (int w = 0; w < bucket_fill[b]; w++) begin
         if (bucket_rows[b][w].kx == kx && bucket_rows[b][w].ky == ky) return w;
      end
      return WAYS;
   endfunction

   // Apply one request to the bucket model and return the response it produces
   function automatic rsp_type hash_table_apply(input request_type r);
      rsp_type res;
      int      b;
      int      w;
      int      n;
      res = '0;
      res.status = ST_OK;
      b = bucket_index(r.kx, r.ky);
      n = bucket_fill[b];
      case (r.op)
         OP_INSERT: begin
            if (n >= WAYS) begin
               res.status = ST_FULL;
            end else begin
               for (w = n; w > 0; w--) bucket_rows[b][w] = bucket_rows[b][w-1];
               bucket_rows[b][0].kx = r.kx;
               bucket_rows[b][0].ky = r.ky;
               bucket_rows[b][0].vx = r.vx;
               bucket_rows[b][0].vy = r.vy;
               bucket_fill[b] = n + 1;
            end
         end
         OP_FIND: begin
            w = newest_way(b, r.kx, r.ky);
            if (w >= WAYS) begin
               res.status = ST_NOT_FOUND;
            end else begin
               res.result_x = bucket_rows[b][w].vx;
               res.result_y = bucket_rows[b][w].vy;
            end
         end
         OP_DELETE: begin
            w = newest_way(b, r.kx, r.ky);
            if (w >= WAYS) begin
               res.status = ST_NOT_FOUND;
            end else begin
               // shift older entries up to keep their order
               for (; w + 1 < n; w++) bucket_rows[b][w] = bucket_rows[b][w+1];
               bucket_rows[b][n-1] = '{default: '0};
               bucket_fill[b] = n - 1;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic request_type make_row(input logic [OP_W-1:0] op,
                                            input logic [FIELD_W-1:0] kx,
                                            input logic [FIELD_W-1:0] ky,
                                            input logic [FIELD_W-1:0] vx,
                                            input logic [FIELD_W-1:0] vy,
                                            input bit typed, input logic [ST_W-1:0] st,
                                            input logic [FIELD_W-1:0] rx,
                                            input logic [FIELD_W-1:0] ry);
      request_type r;
      r.op = op;
      r.kx = kx;
      r.ky = ky;
      r.vx = vx;
      r.vy = vy;
      r.typed = typed;
      r.want.status = st;
      r.want.result_x = rx;
      r.want.result_y = ry;
      return r;
   endfunction

   function automatic request_type random_request();
      request_type r;
      int          pick;
      r.typed = 1'b0;
      r.want = '0;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         // keys that all land in bucket zero
         case ($urandom_range(0, 2))
            0: begin r.kx = 8'd0; r.ky = 8'd0; end
            1: begin r.kx = 8'd1; r.ky = 8'd9; end
            default: begin r.kx = 8'd7; r.ky = 8'd8; end
         endcase
      end else if (pick < 80) begin
         r.kx = FIELD_W'($urandom_range(0, 7));
         r.ky = FIELD_W'($urandom_range(0, 7));
      end else begin
         r.kx = FIELD_W'($urandom_range(0, 255));
         r.ky = FIELD_W'($urandom_range(0, 255));
      end
      r.vx = FIELD_W'($urandom_range(0, 255));
      r.vy = FIELD_W'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 40)      r.op = OP_INSERT;
      else if (pick < 70) r.op = OP_FIND;
      else if (pick < 95) r.op = OP_DELETE;
      else                r.op = OP_NONE;
      return r;
   endfunction

   task automatic send_request(input request_type r);
      rsp_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.op;
      req_tdata  <= {r.vy, r.vx, r.ky, r.kx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = hash_table_apply(r);
      pending_rsp.push_back(r.typed ? r.want : predicted);
      @(negedge clock);
   endtask

   task automatic load_directed_rows();
      directed_rows[0]  = make_row(OP_FIND,   8'h00, 8'h00, 8'hAA, 8'h55, 1'b1,
                                   ST_NOT_FOUND, 8'h00, 8'h00);
      directed_rows[1]  = make_row(OP_DELETE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
                                   ST_NOT_FOUND, 8'h00, 8'h00);
      directed_rows[2]  = make_row(OP_INSERT, 8'h00, 8'h00, 8'hFF, 8'hFF, 1'b1,
                                   ST_OK, 8'h00, 8'h00);
      directed_rows[3]  = make_row(OP_FIND,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
                                   ST_OK, 8'hFF, 8'hFF);
      // the all-ones key also lands in bucket zero
      directed_rows[4]  = make_row(OP_INSERT, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1,
                                   ST_OK, 8'h00, 8'h00);
      directed_rows[5]  = make_row(OP_FIND,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
                                   ST_OK, 8'h00, 8'h00);
      directed_rows[6]  = make_row(OP_NONE,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
                                   ST_OK, 8'h00, 8'h00);
      // stack the same key until the bucket is full
      directed_rows[7]  = make_row(OP_INSERT, 8'h00, 8'h00, 8'h01, 8'h02, 1'b1,
                                   ST_OK, 8'h00, 8'h00);
      directed_rows[8]  = make_row(OP_INSERT, 8'h00, 8'h00, 8'h03, 8'h04, 1'b1,
                                   ST_OK, 8'h00, 8'h00);
      directed_rows[9]  = make_row(OP_INSERT, 8'h00, 8'h00, 8'h05, 8'h06, 1'b1,
                                   ST_FULL, 8'h00, 8'h00);
      directed_rows[10] = make_row(OP_INSERT, 8'h00, 8'h00, 8'h07, 8'h07, 1'b1,
                                   ST_FULL, 8'h00, 8'h00);
      directed_rows[11] = make_row(OP_FIND,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
                                   ST_OK, 8'h03, 8'h04);
      directed_rows[12] = make_row(OP_DELETE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
                                   ST_OK, 8'h00, 8'h00);
      directed_rows[13] = make_row(OP_FIND,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
                                   ST_OK, 8'h01, 8'h02);
      directed_rows[14] = make_row(OP_DELETE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
                                   ST_OK, 8'h00, 8'h00);
      directed_rows[15] = make_row(OP_DELETE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
                                   ST_OK, 8'h00, 8'h00);
      directed_rows[16] = make_row(OP_DELETE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
                                   ST_NOT_FOUND, 8'h00, 8'h00);
      directed_rows[17] = make_row(OP_DELETE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
                                   ST_NOT_FOUND, 8'h00, 8'h00);
      // three keys sharing bucket zero; drop the middle one
      directed_rows[18] = make_row(OP_INSERT, 8'h00, 8'h00, 8'h12, 8'h34, 1'b0,
                                   ST_OK, 8'h00, 8'h00);
      directed_rows[19] = make_row(OP_INSERT, 8'h01, 8'h09, 8'h56, 8'h78, 1'b0,
                                   ST_OK, 8'h00, 8'h00);
      directed_rows[20] = make_row(OP_INSERT, 8'h07, 8'h08, 8'h9A, 8'hBC, 1'b0,
                                   ST_OK, 8'h00, 8'h00);
      directed_rows[21] = make_row(OP_DELETE, 8'h01, 8'h09, 8'h00, 8'h00, 1'b0,
                                   ST_OK, 8'h00, 8'h00);
      directed_rows[22] = make_row(OP_FIND,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
                                   ST_OK, 8'h00, 8'h00);
      directed_rows[23] = make_row(OP_FIND,   8'h07, 8'h08, 8'h00, 8'h00, 1'b0,
                                   ST_OK, 8'h00, 8'h00);
      directed_rows[24] = make_row(OP_FIND,   8'h01, 8'h09, 8'h00, 8'h00, 1'b0,
                                   ST_OK, 8'h00, 8'h00);
   endtask

   // Response side: stall at random, or hold off once for a long stretch
   always @(negedge clock) begin
      if (hold_start && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $error("response with no request pending: status %0d", rsp_tuser);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[7:0] !== want.result_x) begin
               $error("result_x: expected %0d, got %0d", want.result_x, rsp_tdata[7:0]);
               fail_count++;
            end
            if (rsp_tdata[15:8] !== want.result_y) begin
               $error("result_y: expected %0d, got %0d", want.result_y, rsp_tdata[15:8]);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      int idle_of  [PHASES];
      int stall_of [PHASES];
      idle_of  = '{0, 61, 0, 6, 0};
      stall_of = '{0, 0, 61, 6, 0};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_start = 1'b0;
      hold_taken = 1'b0;
      hold_left = 0;
      fail_count = 0;
      cycle_count = 0;
      for (int b = 0; b < BUCKETS; b++) begin
         bucket_fill[b] = 0;
         for (int w = 0; w < WAYS; w++) bucket_rows[b][w] = '{default: '0};
      end
      load_directed_rows();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) send_request(directed_rows[i]);

      for (int ph = 0; ph < PHASES; ph++) begin
         send_idle_pct = idle_of[ph];
         recv_stall_pct = stall_of[ph];
         // keep offering requests while the response side holds off
         if (ph == PRESSURE_PH) hold_start = 1'b1;
         for (int n = 0; n < RANDOM_N / PHASES; n++) send_request(random_request());
      end
      req_tvalid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
